// File: rtl/core/table_binary_linear_search_top_macros.svh
// Assertion macros for the table search block.
`ifndef TABLE_BINARY_LINEAR_SEARCH_TOP_MACROS_SVH
`define TABLE_BINARY_LINEAR_SEARCH_TOP_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define TBLS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbls assertion failed");
// Next-cycle implication, disabled during reset
`define TBLS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbls assertion failed");
`else
`define TBLS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TBLS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/core/tbls_pkg.sv
// Types and constants shared by the table search block.
`default_nettype none
package tbls_pkg;

    localparam int ACTION_W = 2;
    localparam int ADDR_W   = 13;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 13;
    localparam int CNT_W    = 14;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_BINARY = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LINEAR = 2'd2;

    // Register map: register index is paddr[2]
    localparam logic REG_TABLE_SIZE = 1'b0;
    localparam logic [CNT_W-1:0] TABLE_SIZE_RESET = 14'd8192;

    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic [ADDR_W-1:0]         address;
        logic signed [VALUE_W-1:0] value;
    } search_item_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic [CNT_W-1:0] probe_count;
    } result_item_t;

endpackage
`default_nettype wire

// File: rtl/core/tbls_stream_if.sv
// Valid/ready stream channel carrying one payload struct per beat.
`default_nettype none
interface tbls_stream_if #(
    parameter type PAYLOAD_T = logic
) ();
    logic     valid;
    logic     ready;
    PAYLOAD_T data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/tbls_ram.sv
// Single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module tbls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/table_binary_linear_search_top.sv
// Table search block: entry RAM, search sequencer, result register, APB config.
//
// Usage: the search channel takes one beat per item. A load beat (action 0)
// writes one entry in the accept cycle and gives no result; action 3 is
// dropped. A binary (1) or linear (2) search beat gives one result beat on
// the result channel: found flag, position (0 on a miss) and probe count.
// table_size (APB, byte address 0) sets how many entries searches use; it
// is clamped to 1..TABLE_DEPTH and must be written while the block is idle.
// Search steps: a binary search makes k halving steps (k is floor or ceil of
// log2(n)); each step issues an entry RAM read in ST_BIN and uses the
// registered read data in ST_BIN_WAIT. A linear search reads entries from 0
// up and stops at the first hit or at n; the scan issues one RAM read per cycle.
// The search channel is ready only while no search is in progress; a load can
// be accepted while an earlier result still waits in the output register.
// Reset: table_size returns to 8192 and the sequencer goes idle; entry
// contents are left as they were and must be loaded before they are searched.
// Stall: a finished result waits until the output register is free, and the
// output register holds its beat until the receiver takes it.
`default_nettype none
`include "table_binary_linear_search_top_macros.svh"
module table_binary_linear_search_top
    import tbls_pkg::*;
#(
    parameter int TABLE_DEPTH = 8192
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    tbls_stream_if.sink             search,
    tbls_stream_if.source           result,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = (SW > CNT_W) ? SW : CNT_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    // Sequencer states
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_BIN      = 3'd1;
    localparam logic [2:0] ST_BIN_WAIT = 3'd2;
    localparam logic [2:0] ST_FIN_WAIT = 3'd3;
    localparam logic [2:0] ST_LIN      = 3'd4;
    localparam logic [2:0] ST_RES      = 3'd5;

    logic [CNT_W-1:0]          table_size_reg;
    logic [2:0]                state_reg, state_next;
    logic signed [VALUE_W-1:0] key_reg, key_next;
    logic [SW-1:0]             n_reg, n_next;
    logic [AW-1:0]             lo_reg, lo_next;
    logic [AW-1:0]             hi_reg, hi_next;
    logic [SW-1:0]             cnt_reg, cnt_next;
    logic [SW-1:0]             scan_reg, scan_next;
    logic                      chk_valid_reg, chk_valid_next;
    logic [AW-1:0]             chk_idx_reg, chk_idx_next;
    logic                      res_found_reg, res_found_next;
    logic [AW-1:0]             res_pos_reg, res_pos_next;
    logic [SW-1:0]             res_cnt_reg, res_cnt_next;
    logic                      out_valid_reg;
    result_item_t              out_data_reg;

    logic [CW-1:0]             size_ext;
    logic [CW-1:0]             size_eff;
    logic [CW-1:0]             addr_ext;
    logic                      addr_ok;
    logic [AW:0]               mid_sum;
    logic [AW-1:0]             mid;
    logic                      ram_we;
    logic                      ram_re;
    logic [AW-1:0]             ram_raddr;
    logic [VALUE_W-1:0]        ram_rdata;
    logic                      out_load;
    logic [CW-1:0]             pos_ext;
    logic [CW-1:0]             cnt_ext;

    // APB register: write at access phase, read back table_size
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TABLE_SIZE) ? PDATA_W'(table_size_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= TABLE_SIZE_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_TABLE_SIZE))
        begin
            table_size_reg <= pwdata[CNT_W-1:0];
        end
    end

    // Clamp table size to 1..TABLE_DEPTH
    assign size_ext = CW'(table_size_reg);
    always_comb
    begin
        if (size_ext == '0)
        begin
            size_eff = CW'(1);
        end
        else if (size_ext > DEPTH_C)
        begin
            size_eff = DEPTH_C;
        end
        else
        begin
            size_eff = size_ext;
        end
    end

    // Load address decode
    assign addr_ext = CW'(search.data.address);
    assign addr_ok  = (addr_ext < DEPTH_C);

    // Binary midpoint
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[AW:1];

    assign search.ready = (state_reg == ST_IDLE);
    assign ram_we = search.valid && search.ready
                    && (search.data.action == ACT_LOAD) && addr_ok;

    // Sequencer next state and RAM read control
    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        n_next         = n_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        cnt_next       = cnt_reg;
        scan_next      = scan_reg;
        chk_valid_next = chk_valid_reg;
        chk_idx_next   = chk_idx_reg;
        res_found_next = res_found_reg;
        res_pos_next   = res_pos_reg;
        res_cnt_next   = res_cnt_reg;
        ram_re         = 1'b0;
        ram_raddr      = lo_reg;
        out_load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (search.valid)
                begin
                    key_next       = search.data.value;
                    n_next         = size_eff[SW-1:0];
                    lo_next        = '0;
                    hi_next        = AW'(size_eff - CW'(1));
                    cnt_next       = '0;
                    scan_next      = '0;
                    chk_valid_next = 1'b0;
                    case (search.data.action)
                        ACT_BINARY: state_next = ST_BIN;
                        ACT_LINEAR: state_next = ST_LIN;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_BIN:
            begin
                // Probe the midpoint, or the last remaining entry
                ram_re = 1'b1;
                if (lo_reg < hi_reg)
                begin
                    ram_raddr  = mid;
                    state_next = ST_BIN_WAIT;
                end
                else
                begin
                    ram_raddr  = lo_reg;
                    state_next = ST_FIN_WAIT;
                end
            end
            ST_BIN_WAIT:
            begin
                // Halve the range
                cnt_next = cnt_reg + SW'(1);
                if (key_reg > $signed(ram_rdata))
                begin
                    lo_next = mid + AW'(1);
                end
                else
                begin
                    hi_next = mid;
                end
                state_next = ST_BIN;
            end
            ST_FIN_WAIT:
            begin
                res_found_next = (ram_rdata == key_reg);
                res_pos_next   = (ram_rdata == key_reg) ? lo_reg : '0;
                res_cnt_next   = cnt_reg;
                state_next     = ST_RES;
            end
            ST_LIN:
            begin
                // Check the entry read last cycle while issuing the next read
                if (chk_valid_reg && (ram_rdata == key_reg))
                begin
                    res_found_next = 1'b1;
                    res_pos_next   = chk_idx_reg;
                    res_cnt_next   = SW'(chk_idx_reg);
                    state_next     = ST_RES;
                end
                else if (scan_reg < n_reg)
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = scan_reg[AW-1:0];
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_reg[AW-1:0];
                    scan_next      = scan_reg + SW'(1);
                end
                else
                begin
                    res_found_next = 1'b0;
                    res_pos_next   = '0;
                    res_cnt_next   = n_reg;
                    state_next     = ST_RES;
                end
            end
            ST_RES:
            begin
                // Hand the result to the output register once it is free
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_valid_reg <= chk_valid_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        n_reg         <= n_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        cnt_reg       <= cnt_next;
        scan_reg      <= scan_next;
        chk_idx_reg   <= chk_idx_next;
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
        res_cnt_reg   <= res_cnt_next;
        if (out_load)
        begin
            out_data_reg.found       <= res_found_reg;
            out_data_reg.position    <= pos_ext[POS_W-1:0];
            out_data_reg.probe_count <= cnt_ext[CNT_W-1:0];
        end
    end

    assign pos_ext = CW'(res_pos_reg);
    assign cnt_ext = CW'(res_cnt_reg);

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // Entry store
    tbls_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_ext[AW-1:0]),
        .wdata (search.data.value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The linear scan never reads past the table size in use
    `TBLS_ASSERT_IMP(a_scan_in_range, clk, rst_n,
        (state_reg == ST_LIN) && ram_re, CW'(ram_raddr) < CW'(n_reg))
    // The binary range never inverts
    `TBLS_ASSERT_IMP(a_bin_range, clk, rst_n,
        (state_reg == ST_BIN) || (state_reg == ST_BIN_WAIT), lo_reg <= hi_reg)
    // Loads and search reads never share a cycle
    `TBLS_ASSERT_IMP(a_no_rw_overlap, clk, rst_n, ram_we, !ram_re)
    // A finished result waits while the output register is full and stalled
    `TBLS_ASSERT_NXT(a_res_waits, clk, rst_n,
        (state_reg == ST_RES) && out_valid_reg && !result.ready,
        state_reg == ST_RES)

endmodule
`default_nettype wire
